// File: sv/cpd_pkg.sv
// Shared types and constants of the packet deframer core.
package cpd_pkg;

   localparam int HEADER_BYTES = 6;
   localparam int HDR_IDX_W    = 3;
   localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WORD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_A  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_B  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_C  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH_D  = 3'd4;

   localparam logic [31:0] SYNC_WORD_RESET = 32'h1ACF_FC1D;

   typedef enum logic [1:0] {
      MODE_HUNT,
      MODE_HEADER,
      MODE_PAYLOAD
   } mode_type;

   typedef enum logic [1:0] {
      CMD_DATA,
      CMD_HEADER,
      CMD_BAD
   } cmd_kind_type;

   // One classified entry from the front end to the result side
   typedef struct packed {
      cmd_kind_type                      kind;
      logic [7:0]                        data;
      logic                              last_pkt;
      logic [15:0]                       length;
      logic [10:0]                       apid;
      logic [HEADER_BYTES-1:0][7:0]      hdr;
   } cmd_type;

   // One result beat
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        first_of_packet;
      logic        last_of_packet;
      logic        last_of_run;
      logic        status;
      logic [15:0] packet_length;
      logic [10:0] apid;
   } rsp_type;

endpackage

// File: sv/cpd_front.sv
// Front end: sync hunt, header capture, length check and payload classification.
module cpd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             byte_valid,
   input  logic [7:0]                       in_byte,
   input  logic                             csr_we,
   input  logic [cpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cpd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             cmd_push,
   output cpd_pkg::cmd_type                 cmd
);

   cpd_pkg::mode_type mode_ff, mode_in;
   logic [31:0] window_ff, window_in;
   logic [cpd_pkg::HDR_IDX_W-1:0] count_ff, count_in;
   logic [16:0] remain_ff, remain_in;
   logic [7:0]  hdr_ff [cpd_pkg::HEADER_BYTES];

   logic [31:0] sync_word_ff;
   logic [15:0] length_a_ff, length_b_ff, length_c_ff, length_d_ff;

   logic        hunt_hit;
   logic        in_header;
   logic [31:0] shifted;
   logic [cpd_pkg::HDR_IDX_W-1:0] hdr_idx;
   logic        hdr_done;
   logic [15:0] len_new;
   logic        len_ok;
   logic        rem_last;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= cpd_pkg::SYNC_WORD_RESET;
         length_a_ff  <= '0;
         length_b_ff  <= '0;
         length_c_ff  <= '0;
         length_d_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            cpd_pkg::CSR_SYNC_WORD: sync_word_ff <= csr_wdata;
            cpd_pkg::CSR_LENGTH_A:  length_a_ff  <= csr_wdata[15:0];
            cpd_pkg::CSR_LENGTH_B:  length_b_ff  <= csr_wdata[15:0];
            cpd_pkg::CSR_LENGTH_C:  length_c_ff  <= csr_wdata[15:0];
            cpd_pkg::CSR_LENGTH_D:  length_d_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Classify the incoming byte
   assign hunt_hit  = (mode_ff == cpd_pkg::MODE_HUNT) && (window_ff == sync_word_ff);
   assign in_header = (mode_ff == cpd_pkg::MODE_HEADER) || hunt_hit;
   assign shifted   = {window_ff[23:0], in_byte};
   assign hdr_idx   = hunt_hit ? '0 : count_ff;
   assign hdr_done  = (mode_ff == cpd_pkg::MODE_HEADER) && (count_ff == cpd_pkg::HDR_LAST);
   assign len_new   = {hdr_ff[4], in_byte};
   assign len_ok    = (len_new == length_a_ff) || (len_new == length_b_ff) ||
                      (len_new == length_c_ff) || (len_new == length_d_ff);
   assign rem_last  = (remain_ff <= 17'd1);

   // Next state
   always_comb begin
      mode_in   = mode_ff;
      window_in = window_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      if (byte_valid) begin
         unique case (mode_ff)
            cpd_pkg::MODE_HUNT: begin
               if (hunt_hit) begin
                  mode_in  = cpd_pkg::MODE_HEADER;
                  count_in = cpd_pkg::HDR_IDX_W'(1);
               end else begin
                  window_in = shifted;
                  if (shifted == sync_word_ff) begin
                     mode_in  = cpd_pkg::MODE_HEADER;
                     count_in = '0;
                  end
               end
            end
            cpd_pkg::MODE_HEADER: begin
               if (hdr_done) begin
                  if (len_ok) begin
                     mode_in   = cpd_pkg::MODE_PAYLOAD;
                     count_in  = '0;
                     remain_in = {1'b0, len_new} + 17'd1;
                  end else begin
                     mode_in   = cpd_pkg::MODE_HUNT;
                     window_in = '0;
                     count_in  = '0;
                     remain_in = '0;
                  end
               end else begin
                  count_in = count_ff + cpd_pkg::HDR_IDX_W'(1);
               end
            end
            cpd_pkg::MODE_PAYLOAD: begin
               if (rem_last) begin
                  mode_in   = cpd_pkg::MODE_HUNT;
                  window_in = '0;
                  count_in  = '0;
                  remain_in = '0;
               end else begin
                  remain_in = remain_ff - 17'd1;
               end
            end
            default: begin
               mode_in   = cpd_pkg::MODE_HUNT;
               window_in = '0;
               count_in  = '0;
               remain_in = '0;
            end
         endcase
      end
   end

   // Outputs: one entry per header release, bad length or payload byte
   always_comb begin
      cmd_push     = 1'b0;
      cmd.kind     = cpd_pkg::CMD_DATA;
      cmd.data     = in_byte;
      cmd.last_pkt = rem_last;
      cmd.length   = {hdr_ff[4], hdr_ff[5]};
      cmd.apid     = {hdr_ff[0][2:0], hdr_ff[1]};
      for (int i = 0; i < cpd_pkg::HEADER_BYTES - 1; i++) begin
         cmd.hdr[i] = hdr_ff[i];
      end
      cmd.hdr[cpd_pkg::HEADER_BYTES-1] = in_byte;
      unique case (mode_ff)
         cpd_pkg::MODE_HEADER: begin
            if (hdr_done) begin
               cmd_push   = byte_valid;
               cmd.kind   = len_ok ? cpd_pkg::CMD_HEADER : cpd_pkg::CMD_BAD;
               cmd.length = len_new;
            end
         end
         cpd_pkg::MODE_PAYLOAD: begin
            cmd_push = byte_valid;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cpd_pkg::MODE_HUNT;
         window_ff <= '0;
         count_ff  <= '0;
         remain_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         window_ff <= window_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
      end
   end

   // Capture header bytes
   always_ff @(posedge clock) begin
      if (byte_valid && in_header) begin
         hdr_ff[hdr_idx] <= in_byte;
      end
   end

endmodule

// File: sv/cpd_cmd_queue.sv
// Short queue of classified entries between the front end and the result side.
module cpd_cmd_queue #(
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cpd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output cpd_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cpd_pkg::cmd_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: sv/cpd_back.sv
// Result side: expands queued entries into result beats held in an output register.
module cpd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  cpd_pkg::cmd_type q_head,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_valid,
   output cpd_pkg::rsp_type rsp
);

   cpd_pkg::cmd_type              cur_ff, cur_in;
   logic                          burst_ff, burst_in;
   logic [cpd_pkg::HDR_IDX_W-1:0] idx_ff, idx_in;
   logic                          valid_ff, valid_in;
   cpd_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          slot_free;
   logic                          emit;

   assign slot_free = !valid_ff || rsp_pop;

   // Pick the next beat: rest of a header burst first, else the queue head
   always_comb begin
      cur_in   = cur_ff;
      burst_in = burst_ff;
      idx_in   = idx_ff;
      rsp_in   = rsp_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      if (slot_free) begin
         if (burst_ff) begin
            emit                   = 1'b1;
            rsp_in.out_byte        = cur_ff.hdr[idx_ff];
            rsp_in.first_of_packet = 1'b0;
            rsp_in.last_of_packet  = 1'b0;
            rsp_in.last_of_run     = (idx_ff == cpd_pkg::HDR_LAST);
            rsp_in.status          = 1'b0;
            rsp_in.packet_length   = cur_ff.length;
            rsp_in.apid            = cur_ff.apid;
            idx_in                 = idx_ff + cpd_pkg::HDR_IDX_W'(1);
            if (idx_ff == cpd_pkg::HDR_LAST) begin
               burst_in = 1'b0;
            end
         end else if (q_valid) begin
            emit                 = 1'b1;
            q_pop                = 1'b1;
            cur_in               = q_head;
            rsp_in.packet_length = q_head.length;
            rsp_in.apid          = q_head.apid;
            unique case (q_head.kind)
               cpd_pkg::CMD_HEADER: begin
                  rsp_in.out_byte        = q_head.hdr[0];
                  rsp_in.first_of_packet = 1'b1;
                  rsp_in.last_of_packet  = 1'b0;
                  rsp_in.last_of_run     = 1'b0;
                  rsp_in.status          = 1'b0;
                  burst_in               = 1'b1;
                  idx_in                 = cpd_pkg::HDR_IDX_W'(1);
               end
               cpd_pkg::CMD_BAD: begin
                  rsp_in.out_byte        = '0;
                  rsp_in.first_of_packet = 1'b0;
                  rsp_in.last_of_packet  = 1'b0;
                  rsp_in.last_of_run     = 1'b1;
                  rsp_in.status          = 1'b1;
               end
               default: begin
                  rsp_in.out_byte        = q_head.data;
                  rsp_in.first_of_packet = 1'b0;
                  rsp_in.last_of_packet  = q_head.last_pkt;
                  rsp_in.last_of_run     = 1'b1;
                  rsp_in.status          = 1'b0;
               end
            endcase
         end
      end
      valid_in = emit || (valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         burst_ff <= burst_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/ccsds_packet_deframer_core.sv
// Top level of the packet deframer: front end, entry queue and result side.
//
// Input: one stream byte per beat on req_in_byte, taken when req_push is high
// and req_full is low. Results: while rsp_empty is low the oldest result sits
// on the rsp_ ports and is taken when rsp_pop is high.
// Configuration: csr_we writes csr_wdata into register csr_index (0 sync word,
// 1..4 allowed lengths) at the same edge; indexes beyond 4 are ignored.
// Throughput: one input byte per cycle while req_full is low, one result beat per cycle
// while results are popped. A header release is six beats leaving the result side one
// after another; payload entries wait in the QUEUE_DEPTH-entry queue meanwhile, and the
// sync and header bytes of the next packet give that backlog time to drain.
// Path: the edge that takes a byte writes its entry into the queue; the output register
// loads it once the slot is free and no header burst is ahead, and it is then on the ports.
// Reset: hunt mode with a cleared window, empty queue, no result pending,
// configuration registers back to their defaults.
// Stall: a result not popped holds in the output register; entries then pile
// up in the queue and req_full rises once it is full.
module ccsds_packet_deframer_core #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [7:0]                       req_in_byte,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_first_of_packet,
   output logic                             rsp_last_of_packet,
   output logic                             rsp_last_of_run,
   output logic                             rsp_status,
   output logic [15:0]                      rsp_packet_length,
   output logic [10:0]                      rsp_apid,
   input  logic                             csr_we,
   input  logic [cpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic             byte_valid;
   logic             cmd_push;
   cpd_pkg::cmd_type cmd;
   cpd_pkg::cmd_type q_head;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   logic             rsp_valid;
   cpd_pkg::rsp_type rsp;

   assign byte_valid = req_push && !q_full;
   assign req_full   = q_full;

   cpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .in_byte    (req_in_byte),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   cpd_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   cpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (!q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // Drive result ports from the output register
   assign rsp_empty           = !rsp_valid;
   assign rsp_out_byte        = rsp.out_byte;
   assign rsp_first_of_packet = rsp.first_of_packet;
   assign rsp_last_of_packet  = rsp.last_of_packet;
   assign rsp_last_of_run     = rsp.last_of_run;
   assign rsp_status          = rsp.status;
   assign rsp_packet_length   = rsp.packet_length;
   assign rsp_apid            = rsp.apid;

   // Nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // The result side never takes from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // A queued entry reaches the output register when the slot is free
   a_pop_fills: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !rsp_empty)
      else $error("popped entry produced no result");

   // A bad-length result ends its run and carries a zero byte
   a_bad_beat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status) |->
         (rsp_last_of_run && (rsp_out_byte == 8'd0) && !rsp_first_of_packet))
      else $error("malformed bad-length result");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CCSDS packet deframer core.
module tb_top;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int REPORT_LIMIT  = 10;
   localparam int HOLD_CYCLES   = 400;
   localparam int SMALL_LENGTH  = 40;
   localparam int PHASE_BUDGET  = 36;
   localparam int DIRECTED_ROWS = 22;

   localparam logic [cpd_pkg::CSR_INDEX_W-1:0] CSR_FIRST_UNUSED =
      cpd_pkg::CSR_LENGTH_D + 1'b1;
   localparam logic [cpd_pkg::CSR_INDEX_W-1:0] CSR_LAST_UNUSED  = '1;

   typedef struct {
      logic [7:0]       in_byte;
      bit               typed;
      cpd_pkg::rsp_type want;
   } stim_row_type;

   // Beats that can be read straight off the stream
   localparam cpd_pkg::rsp_type LONE_PAYLOAD_BEAT = '{out_byte: 8'hFF,
      first_of_packet: 1'b0, last_of_packet: 1'b1, last_of_run: 1'b1, status: 1'b0,
      packet_length: 16'h0000, apid: 11'h000};
   localparam cpd_pkg::rsp_type BAD_LENGTH_BEAT = '{out_byte: 8'h00,
      first_of_packet: 1'b0, last_of_packet: 1'b0, last_of_run: 1'b1, status: 1'b1,
      packet_length: 16'hFFFF, apid: 11'h7FF};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic [7:0]                      req_in_byte = 8'h00;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic [7:0]                      rsp_out_byte;
   logic                            rsp_first_of_packet;
   logic                            rsp_last_of_packet;
   logic                            rsp_last_of_run;
   logic                            rsp_status;
   logic [15:0]                     rsp_packet_length;
   logic [10:0]                     rsp_apid;
   logic                            csr_we = 1'b0;
   logic [cpd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [cpd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Deframer state as the bench tracks it
   cpd_pkg::mode_type dfr_mode;
   logic [31:0]       sync_reg;
   logic [31:0]       sync_window;
   logic [15:0]       length_reg [4];
   logic [7:0]        header_bytes [cpd_pkg::HEADER_BYTES];
   int                header_fill;
   logic [16:0]       payload_left;

   cpd_pkg::rsp_type awaited_beats [$];
   stim_row_type     pending_bytes [$];
   int               mismatches = 0;
   bit               long_hold = 1'b0;
   int               hold_left = 0;
   int               pattern_age = 0;
   logic [7:0]       stall_pattern = 8'hFF;

   // Sync slip, a length-zero packet, then a header with a length not allowed
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h1A, 1'b0, '0}, '{8'h1A, 1'b0, '0}, '{8'hCF, 1'b0, '0}, '{8'hFC, 1'b0, '0},
      '{8'h1D, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b1, LONE_PAYLOAD_BEAT},
      '{8'h1A, 1'b0, '0}, '{8'hCF, 1'b0, '0}, '{8'hFC, 1'b0, '0}, '{8'h1D, 1'b0, '0},
      '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b1, BAD_LENGTH_BEAT}
   };

   ccsds_packet_deframer_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_in_byte         (req_in_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_first_of_packet (rsp_first_of_packet),
      .rsp_last_of_packet  (rsp_last_of_packet),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_status          (rsp_status),
      .rsp_packet_length   (rsp_packet_length),
      .rsp_apid            (rsp_apid),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic cpd_pkg::rsp_type make_beat(logic [7:0] data, logic first,
                                                  logic last_pkt, logic last_run,
                                                  logic bad);
      cpd_pkg::rsp_type beat;
      beat.out_byte        = data;
      beat.first_of_packet = first;
      beat.last_of_packet  = last_pkt;
      beat.last_of_run     = last_run;
      beat.status          = bad;
      beat.packet_length   = {header_bytes[4], header_bytes[5]};
      beat.apid            = {header_bytes[0][2:0], header_bytes[1]};
      return beat;
   endfunction

   function automatic void restart_hunt();
      dfr_mode     = cpd_pkg::MODE_HUNT;
      sync_window  = '0;
      header_fill  = 0;
      payload_left = '0;
   endfunction

   function automatic bit length_allowed(logic [15:0] len);
      foreach (length_reg[i]) begin
         if (length_reg[i] == len) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the deframer by one stream byte and queue the beats it releases
   function automatic void deframe_byte(logic [7:0] data);
      logic [15:0] hdr_len;
      logic        closing;
      if (dfr_mode == cpd_pkg::MODE_HUNT) begin
         if (sync_window == sync_reg) begin
            // window already matched: this byte opens the header
            dfr_mode    = cpd_pkg::MODE_HEADER;
            header_fill = 0;
         end else begin
            sync_window = {sync_window[23:0], data};
            if (sync_window == sync_reg) begin
               dfr_mode    = cpd_pkg::MODE_HEADER;
               header_fill = 0;
            end
            return;
         end
      end
      if (dfr_mode == cpd_pkg::MODE_HEADER) begin
         header_bytes[header_fill] = data;
         header_fill++;
         if (header_fill < cpd_pkg::HEADER_BYTES) return;
         hdr_len = {header_bytes[4], header_bytes[5]};
         if (length_allowed(hdr_len)) begin
            for (int k = 0; k < cpd_pkg::HEADER_BYTES; k++)
               awaited_beats.push_back(make_beat(header_bytes[k], k == 0, 1'b0,
                                                 k == cpd_pkg::HEADER_BYTES - 1, 1'b0));
            dfr_mode     = cpd_pkg::MODE_PAYLOAD;
            header_fill  = 0;
            payload_left = 17'(hdr_len) + 17'd1;
         end else begin
            awaited_beats.push_back(make_beat(8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
            restart_hunt();
         end
         return;
      end
      closing = (payload_left <= 17'd1);
      awaited_beats.push_back(make_beat(data, 1'b0, closing, 1'b1, 1'b0));
      if (closing) restart_hunt();
      else payload_left = payload_left - 17'd1;
   endfunction

   // Record an accepted beat; typed rows replace what the deframer model gives
   function automatic void take_row(stim_row_type row);
      int before_count;
      before_count = awaited_beats.size();
      deframe_byte(row.in_byte);
      if (row.typed) begin
         while (awaited_beats.size() > before_count) void'(awaited_beats.pop_back());
         awaited_beats.push_back(row.want);
      end
   endfunction

   // ------------------------------------------------------------ stream building

   function automatic void add_byte(logic [7:0] data);
      pending_bytes.push_back('{data, 1'b0, '0});
   endfunction

   function automatic void add_sync();
      if (sync_reg != '0) begin
         for (int i = 3; i >= 0; i--) add_byte(sync_reg[8*i +: 8]);
      end
   endfunction

   function automatic logic [15:0] good_length();
      logic [15:0] picks [$];
      foreach (length_reg[i]) begin
         if (length_reg[i] <= SMALL_LENGTH) picks.push_back(length_reg[i]);
      end
      if (picks.size() == 0) return length_reg[0];
      return picks[$urandom_range(0, picks.size() - 1)];
   endfunction

   function automatic logic [15:0] bad_length();
      logic [15:0] len;
      len = 16'($urandom);
      if ($urandom_range(0, 1) == 0) len = good_length() + 16'd1;
      while (length_allowed(len)) len = 16'($urandom);
      return len;
   endfunction

   function automatic void add_packet(logic [15:0] len, bit with_payload);
      logic [10:0] apid;
      apid = 11'($urandom);
      add_sync();
      add_byte({5'($urandom), apid[10:8]});
      add_byte(apid[7:0]);
      add_byte(8'($urandom));
      add_byte(8'($urandom));
      add_byte(len[15:8]);
      add_byte(len[7:0]);
      if (with_payload) begin
         for (int i = 0; i <= int'(len); i++) add_byte(8'($urandom));
      end
   endfunction

   // ------------------------------------------------------------------- driving

   task automatic write_csr(logic [cpd_pkg::CSR_INDEX_W-1:0] index, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         cpd_pkg::CSR_SYNC_WORD: sync_reg      = value;
         cpd_pkg::CSR_LENGTH_A:  length_reg[0] = value[15:0];
         cpd_pkg::CSR_LENGTH_B:  length_reg[1] = value[15:0];
         cpd_pkg::CSR_LENGTH_C:  length_reg[2] = value[15:0];
         cpd_pkg::CSR_LENGTH_D:  length_reg[3] = value[15:0];
         default: ;
      endcase
   endtask

   // Offer pending bytes in bursts with random gaps between them
   task automatic feed_stream();
      int burst;
      int gap;
      while (pending_bytes.size() != 0) begin
         burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
         while (burst > 0 && pending_bytes.size() != 0) begin
            req_push    <= 1'b1;
            req_in_byte <= pending_bytes[0].in_byte;
            do @(posedge clock); while (req_full);
            take_row(pending_bytes.pop_front());
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_push <= 1'b0;
   endtask

   // Wait for every awaited beat, then let the front end go quiet
   task automatic settle();
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [31:0] sync_value, logic [15:0] len_c, logic [15:0] len_d);
      write_csr(cpd_pkg::CSR_SYNC_WORD, sync_value);
      write_csr(cpd_pkg::CSR_LENGTH_A, {16'($urandom), 16'($urandom_range(0, 12))});
      write_csr(cpd_pkg::CSR_LENGTH_B,
                {16'($urandom), 16'($urandom_range(0, SMALL_LENGTH))});
      write_csr(cpd_pkg::CSR_LENGTH_C, {16'($urandom), len_c});
      write_csr(cpd_pkg::CSR_LENGTH_D, {16'($urandom), len_d});
      write_csr(3'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)), $urandom);
      csr_we <= 1'b0;
      // mostly well-formed packets, some bad lengths, cut headers and noise
      while (pending_bytes.size() < PHASE_BUDGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: add_packet(good_length(), 1'b1);
            6: add_packet(bad_length(), 1'b0);
            7: begin
               add_sync();
               repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
            end
            default: repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
         endcase
      end
      feed_stream();
      settle();
   endtask

   // Push single bytes until the deframer hunts with a nonzero window
   task automatic leave_in_hunt();
      while (!(dfr_mode == cpd_pkg::MODE_HUNT && sync_window != '0)) begin
         add_byte(8'($urandom_range(1, 255)));
         feed_stream();
         settle();
      end
   endtask

   // ------------------------------------------------------------------ receiver

   // Pop on a shifting pattern; once, hold off long enough to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (long_hold) begin
         rsp_pop   <= 1'b0;
         hold_left = hold_left + 1;
         if (hold_left >= HOLD_CYCLES) long_hold = 1'b0;
      end else begin
         if (pattern_age == 0) begin
            stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            pattern_age   = $urandom_range(16, 64);
         end
         pattern_age = pattern_age - 1;
         rsp_pop <= stall_pattern[pattern_age % 8];
      end
   end

   function automatic string beat_text(cpd_pkg::rsp_type beat);
      return $sformatf("byte %h first %b last_pkt %b last_run %b status %b length %h apid %h",
                       beat.out_byte, beat.first_of_packet, beat.last_of_packet,
                       beat.last_of_run, beat.status, beat.packet_length, beat.apid);
   endfunction

   // Compare each popped beat with the oldest awaited one
   always @(posedge clock) begin
      cpd_pkg::rsp_type seen;
      cpd_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         seen = '{rsp_out_byte, rsp_first_of_packet, rsp_last_of_packet, rsp_last_of_run,
                  rsp_status, rsp_packet_length, rsp_apid};
         if (awaited_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected beat: %s", beat_text(seen));
         end else begin
            want = awaited_beats.pop_front();
            if (seen.out_byte !== want.out_byte ||
                seen.first_of_packet !== want.first_of_packet ||
                seen.last_of_packet !== want.last_of_packet ||
                seen.last_of_run !== want.last_of_run ||
                seen.status !== want.status ||
                seen.packet_length !== want.packet_length ||
                seen.apid !== want.apid) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("beat mismatch at %0t", $realtime);
                  $display("  expected %s", beat_text(want));
                  $display("  actual   %s", beat_text(seen));
               end
            end
         end
      end
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[ccsds_packet_deframer_core] ERROR");
      $finish;
   end

   // -------------------------------------------------------------------- main

   initial begin
      sync_reg = cpd_pkg::SYNC_WORD_RESET;
      foreach (length_reg[i]) length_reg[i] = '0;
      foreach (header_bytes[i]) header_bytes[i] = '0;
      restart_hunt();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed rows under reset defaults
      foreach (directed_rows[i]) pending_bytes.push_back(directed_rows[i]);
      feed_stream();
      settle();

      // random phases over sync word and length extremes
      run_phase(cpd_pkg::SYNC_WORD_RESET, 16'h0000, 16'hFFFF);
      run_phase(32'h0000_0000, 16'($urandom_range(0, SMALL_LENGTH)), 16'h0000);
      run_phase(32'hFFFF_FFFF, 16'hFFFF, 16'($urandom_range(0, SMALL_LENGTH)));
      hold_left = 0;
      long_hold = 1'b1;
      run_phase($urandom, 16'($urandom), 16'($urandom_range(0, SMALL_LENGTH)));
      run_phase({16'h0000, 16'($urandom)}, 16'($urandom_range(0, SMALL_LENGTH)), 16'hFFFF);
      leave_in_hunt();
      run_phase(sync_window, 16'($urandom_range(0, SMALL_LENGTH)), 16'($urandom));
      run_phase($urandom, 16'h0000, 16'($urandom_range(0, SMALL_LENGTH)));
      run_phase(cpd_pkg::SYNC_WORD_RESET, 16'($urandom),
                16'($urandom_range(0, SMALL_LENGTH)));

      // a zero-length packet, then a short one
      write_csr(cpd_pkg::CSR_SYNC_WORD, cpd_pkg::SYNC_WORD_RESET);
      write_csr(cpd_pkg::CSR_LENGTH_A, 32'h0000_0000);
      write_csr(cpd_pkg::CSR_LENGTH_B, 32'($urandom_range(1, SMALL_LENGTH)));
      write_csr(cpd_pkg::CSR_LENGTH_C, 32'($urandom_range(1, SMALL_LENGTH)));
      write_csr(cpd_pkg::CSR_LENGTH_D, 32'h0000_FFFF);
      csr_we <= 1'b0;
      add_packet(16'h0000, 1'b1);
      add_packet(good_length(), 1'b1);
      feed_stream();
      settle();

      if (mismatches == 0)
         $display("[ccsds_packet_deframer_core] OK");
      else
         $display("[ccsds_packet_deframer_core] ERROR");
      $finish;
   end

endmodule
